// ----- rtl/core/rhd_pkg.sv -----
package rhd_pkg;

    localparam int unsigned HDR_BYTES  = 32;
    localparam int unsigned HDR_W      = HDR_BYTES * 8;
    localparam int unsigned STORE_W    = HDR_W - 8;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    // Depth of the queue between the front and back parts (a power of two).
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC       = 2'd0,
        CFG_VERSION     = 2'd1,
        CFG_TYPE        = 2'd2,
        CFG_MAX_PAYLOAD = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SHORT     = 4'd1,
        ERR_MAGIC     = 4'd2,
        ERR_VERSION   = 4'd3,
        ERR_TYPE      = 4'd4,
        ERR_RESERVED  = 4'd5,
        ERR_ID_ZERO   = 4'd6,
        ERR_STATUS    = 4'd7,
        ERR_TOO_LARGE = 4'd8
    } t_err;

    // One classified packet: either a complete header or a too-short marker.
    typedef struct packed {
        logic              short_pkt;
        logic [HDR_W-1:0]  hdr;
    } t_hdr_rec;

endpackage

// ----- rtl/core/rhd_front.sv -----
module rhd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last_byte,
    output logic                      o_push,
    output rhd_pkg::t_hdr_rec         o_rec
);

    logic [rhd_pkg::CNT_W-1:0]   r_count;
    logic [rhd_pkg::CNT_W-1:0]   n_count;
    logic [rhd_pkg::STORE_W-1:0] r_store;

    logic skipping;
    logic final_byte;

    assign skipping   = (r_count == rhd_pkg::CNT_W'(rhd_pkg::HDR_BYTES));
    assign final_byte = (r_count == rhd_pkg::CNT_W'(rhd_pkg::HDR_BYTES - 1));

    always_comb begin
        n_count         = r_count;
        o_push          = 1'b0;
        o_rec.short_pkt = 1'b0;
        o_rec.hdr       = {i_data_byte, r_store};
        if (i_accept) begin
            if (skipping) begin
                if (i_last_byte) begin
                    n_count = '0;
                end
            end else if (final_byte) begin
                o_push  = 1'b1;
                n_count = i_last_byte ? '0 : rhd_pkg::CNT_W'(rhd_pkg::HDR_BYTES);
            end else if (i_last_byte) begin
                o_push          = 1'b1;
                o_rec.short_pkt = 1'b1;
                o_rec.hdr       = '0;
                n_count         = '0;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Header bytes shift in from the top, so byte 0 ends at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_accept && !skipping && !final_byte) begin
            r_store <= {i_data_byte, r_store[rhd_pkg::STORE_W-1:8]};
        end
    end

endmodule

// ----- rtl/core/rhd_queue.sv -----
module rhd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rhd_pkg::t_hdr_rec i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output rhd_pkg::t_hdr_rec o_rec,
    output logic              o_empty
);

    rhd_pkg::t_hdr_rec r_mem [rhd_pkg::QDEPTH];

    logic [rhd_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [rhd_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [rhd_pkg::QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == rhd_pkg::QCNT_W'(rhd_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ----- rtl/core/rhd_back.sv -----
module rhd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rhd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rhd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  rhd_pkg::t_hdr_rec             i_rec,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [3:0]                    o_error_code,
    output logic [rhd_pkg::HDR_W-1:0]     o_hdr
);

    logic [63:0] r_exp_magic;
    logic [7:0]  r_exp_version;
    logic [7:0]  r_type_code;
    logic [31:0] r_max_payload;

    logic                     r_out_valid;
    rhd_pkg::t_err            r_err;
    rhd_pkg::t_err            n_err;
    logic [rhd_pkg::HDR_W-1:0] r_hdr;

    logic [63:0] magic;
    logic [7:0]  version;
    logic [7:0]  ptype;
    logic [15:0] reserved;
    logic [31:0] req_id;
    logic [31:0] plen;
    logic [31:0] status;

    assign magic    = i_rec.hdr[63:0];
    assign version  = i_rec.hdr[71:64];
    assign ptype    = i_rec.hdr[79:72];
    assign reserved = i_rec.hdr[95:80];
    assign req_id   = i_rec.hdr[159:128];
    assign plen     = i_rec.hdr[191:160];
    assign status   = i_rec.hdr[223:192];

    assign o_q_pop      = !i_q_empty && (!r_out_valid || i_pop);
    assign o_empty      = !r_out_valid;
    assign o_error_code = r_err;
    assign o_hdr        = r_hdr;

    // Checks in priority order; the first failure wins.
    always_comb begin
        if (i_rec.short_pkt) begin
            n_err = rhd_pkg::ERR_SHORT;
        end else if (magic != r_exp_magic) begin
            n_err = rhd_pkg::ERR_MAGIC;
        end else if (version != r_exp_version) begin
            n_err = rhd_pkg::ERR_VERSION;
        end else if (ptype != r_type_code) begin
            n_err = rhd_pkg::ERR_TYPE;
        end else if (reserved != '0) begin
            n_err = rhd_pkg::ERR_RESERVED;
        end else if (req_id == '0) begin
            n_err = rhd_pkg::ERR_ID_ZERO;
        end else if (status != '0) begin
            n_err = rhd_pkg::ERR_STATUS;
        end else if (plen > r_max_payload) begin
            n_err = rhd_pkg::ERR_TOO_LARGE;
        end else begin
            n_err = rhd_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= '0;
            r_type_code   <= '0;
            r_max_payload <= '0;
        end else if (i_cfg_we) begin
            case (rhd_pkg::t_cfg_idx'(i_cfg_index))
                rhd_pkg::CFG_MAGIC:       r_exp_magic   <= i_cfg_data;
                rhd_pkg::CFG_VERSION:     r_exp_version <= i_cfg_data[7:0];
                rhd_pkg::CFG_TYPE:        r_type_code   <= i_cfg_data[7:0];
                rhd_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_err <= n_err;
            r_hdr <= i_rec.hdr;
        end
    end

endmodule

// ----- rtl/core/request_header_decoder.sv -----
// A completed header passes through the queue into the output register and ports.
// Throughput: one byte per cycle, sustained while results are popped as they appear.
// The two-entry queue between the byte front end and the checking stage sets the slack.
// Reset (synchronous, active low) clears the byte count, the queue, the configuration
// and valid flag; the byte store holds no reset and is only read once fully written.
module request_header_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    input  logic                           i_cfg_we,
    input  logic [rhd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rhd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [3:0]                     o_error_code,
    output logic [63:0]                    o_magic_value,
    output logic [7:0]                     o_version_value,
    output logic [7:0]                     o_type_value,
    output logic [15:0]                    o_reserved_value,
    output logic [31:0]                    o_opcode_value,
    output logic [31:0]                    o_request_id_value,
    output logic [31:0]                    o_payload_length_value,
    output logic [31:0]                    o_status_value,
    output logic [31:0]                    o_payload_crc_value
);

    // The front end counts header bytes and gathers them in a shift line.
    // On the 32nd byte, or on a last byte that arrives early, it pushes one
    // record into the queue; payload bytes after the header are dropped.
    logic              in_accept;
    logic              front_push;
    rhd_pkg::t_hdr_rec front_rec;

    // Queue towards the back end.
    rhd_pkg::t_hdr_rec q_rec;
    logic              q_empty;
    logic              q_pop;

    logic [rhd_pkg::HDR_W-1:0] out_hdr;

    // A transaction on the input side needs only room in the queue, so the
    // front end keeps taking bytes while the back end waits on the consumer.
    assign in_accept = i_push && !o_full;

    rhd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (front_push),
        .o_rec       (front_rec)
    );

    rhd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_rec   (front_rec),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_rec   (q_rec),
        .o_empty (q_empty)
    );

    // The back end holds the configuration, runs the checks in priority
    // order and keeps the result in an output register until it is popped.
    rhd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rec        (q_rec),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_error_code (o_error_code),
        .o_hdr        (out_hdr)
    );

    // Little-endian field layout of the header.
    assign o_magic_value          = out_hdr[63:0];
    assign o_version_value        = out_hdr[71:64];
    assign o_type_value           = out_hdr[79:72];
    assign o_reserved_value       = out_hdr[95:80];
    assign o_opcode_value         = out_hdr[127:96];
    assign o_request_id_value     = out_hdr[159:128];
    assign o_payload_length_value = out_hdr[191:160];
    assign o_status_value         = out_hdr[223:192];
    assign o_payload_crc_value    = out_hdr[255:224];

endmodule
